// ----- design/segment_box_table_occlusion_macros.svh -----
// Assertion macros for the segment box table occlusion block.
// Included by modules that carry concurrent checks; no other dependency.
`ifndef SEGMENT_BOX_TABLE_OCCLUSION_MACROS_SVH
`define SEGMENT_BOX_TABLE_OCCLUSION_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SBTO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl failed");
// Condition that must never hold outside reset.
`define SBTO_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("lbl hit");
`endif

// ----- design/sbto_pkg.sv -----
// Package for the segment box table occlusion block: types and outcode bits.
// No dependencies.
`default_nettype none
package sbto_pkg;
  localparam logic [3:0] CodeLeft   = 4'd1;
  localparam logic [3:0] CodeRight  = 4'd2;
  localparam logic [3:0] CodeBottom = 4'd4;
  localparam logic [3:0] CodeTop    = 4'd8;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StTest,
    StDone
  } sbto_state_e;

  // Sign of a difference as a pair: pos, neg.
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;
endpackage
`default_nettype wire

// ----- design/segment_box_table_occlusion.sv -----
// Top level of the segment box table occlusion block: sequencer, box RAM, test unit.
// Depends on sbto_pkg, sbto_ram, sbto_box_test and the macros header.
//
//  channel | ports                                             | accepted at
//  --------+---------------------------------------------------+-------------------
//  item    | kind_i, entry_index_i, box_*_i, start_*_i, end_*_i | start & !busy
//  result  | blocked_o                                         | done_o, one cycle
//  config  | cfg_wdata_i                                       | cfg_we_i
//
// A query walks the table box by box (read, test per box, then report)
// through the single box test unit fed from the one RAM read port. The
// walk stops at the first hit. Reset clears the sequencer and the count;
// the table holds junk until loaded. Results cannot be stalled.
`default_nettype none
`include "segment_box_table_occlusion_macros.svh"
module segment_box_table_occlusion #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic                  kind_i,
  input  wire logic [5:0]            entry_index_i,
  input  wire logic signed [COORD_BITS-1:0] box_min_x_i,
  input  wire logic signed [COORD_BITS-1:0] box_min_y_i,
  input  wire logic signed [COORD_BITS-1:0] box_max_x_i,
  input  wire logic signed [COORD_BITS-1:0] box_max_y_i,
  input  wire logic signed [COORD_BITS-1:0] start_x_i,
  input  wire logic signed [COORD_BITS-1:0] start_y_i,
  input  wire logic signed [COORD_BITS-1:0] end_x_i,
  input  wire logic signed [COORD_BITS-1:0] end_y_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [6:0]            cfg_wdata_i,
  output      logic                  done_o,
  output      logic                  blocked_o
);
  import sbto_pkg::*;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int EW = 4 * COORD_BITS;

  sbto_state_e state_q, state_d;
  logic [6:0]  count_q;
  logic [CW-1:0] idx_q, idx_d, limit;
  logic hit_q, hit_d;
  logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [EW-1:0] rdata;
  logic box_hit, accept, we;

  assign accept = start && !busy;
  assign we = accept && !kind_i && ({26'd0, entry_index_i} < 32'(MAX_BOXES));

  // Clamp the count to the table depth
  assign limit = (32'(count_q) > 32'(MAX_BOXES)) ? CW'(MAX_BOXES) : CW'(count_q);

  sbto_ram #(.Width(EW), .Depth(MAX_BOXES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({box_min_x_i, box_min_y_i, box_max_x_i, box_max_y_i}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  sbto_box_test #(.CoordBits(COORD_BITS)) u_test (
    .lx_i (rdata[4*COORD_BITS-1:3*COORD_BITS]),
    .by_i (rdata[3*COORD_BITS-1:2*COORD_BITS]),
    .rx_i (rdata[2*COORD_BITS-1:COORD_BITS]),
    .ty_i (rdata[COORD_BITS-1:0]),
    .x1_i (x1_q), .y1_i (y1_q), .x2_i (x2_q), .y2_i (y2_q),
    .hit_o (box_hit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    case (state_q)
      StIdle: begin
        if (accept && kind_i) begin
          idx_d = '0;
          hit_d = 1'b0;
          state_d = (limit == '0) ? StDone : StRead;
        end
      end
      StRead: state_d = StTest;
      StTest: begin
        if (box_hit) begin
          hit_d = 1'b1;
          state_d = StDone;
        end else if (idx_q + CW'(1) >= limit) begin
          state_d = StDone;
        end else begin
          idx_d = idx_q + CW'(1);
          state_d = StRead;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state_q != StIdle);
    done_o = (state_q == StDone);
    blocked_o = hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
    end
  end

  // Latch the segment on a query
  always_ff @(posedge clk_i) begin
    if (accept && kind_i) begin
      x1_q <= start_x_i;
      y1_q <= start_y_i;
      x2_q <= end_x_i;
      y2_q <= end_y_i;
    end
  end

  `SBTO_ASSERT(a_done_one, clk_i, rst_ni, done_o |=> !done_o)
  `SBTO_ASSERT(a_idx_lim, clk_i, rst_ni, (state_q == StTest) |-> (idx_q < limit))
  `SBTO_ASSERT(a_no_acc, clk_i, rst_ni, busy |-> !accept)
  `SBTO_NEVER(a_done_idle, clk_i, rst_ni, done_o && !busy)
endmodule
`default_nettype wire

// ----- design/sbto_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module sbto_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/sbto_box_test.sv -----
// Box test unit: outcodes and a test on each edge of one box against the segment.
// Depends on sbto_pkg.
`default_nettype none
module sbto_box_test #(
  parameter int CoordBits = 16
) (
  input  wire logic signed [CoordBits-1:0] lx_i,
  input  wire logic signed [CoordBits-1:0] by_i,
  input  wire logic signed [CoordBits-1:0] rx_i,
  input  wire logic signed [CoordBits-1:0] ty_i,
  input  wire logic signed [CoordBits-1:0] x1_i,
  input  wire logic signed [CoordBits-1:0] y1_i,
  input  wire logic signed [CoordBits-1:0] x2_i,
  input  wire logic signed [CoordBits-1:0] y2_i,
  output      logic                        hit_o
);
  import sbto_pkg::*;
  localparam int W = CoordBits + 1;

  logic [3:0] ca, cb;
  logic edge_l, edge_r, edge_b, edge_t;

  // Sign of a product of two signed differences, without multiplying
  function automatic sgn_t mul_sgn(input sgn_t a, input sgn_t b);
    sgn_t res;
    res.pos = (a.pos & b.pos) | (a.neg & b.neg);
    res.neg = (a.pos & b.neg) | (a.neg & b.pos);
    return res;
  endfunction

  function automatic sgn_t diff_sgn(input logic signed [W-1:0] a,
                                    input logic signed [W-1:0] b);
    sgn_t res;
    res.pos = a > b;
    res.neg = a < b;
    return res;
  endfunction

  // Signed area sign of (a,b,c) where segment a-b lies on an axis, so one of
  // the two product terms is zero and only signs are needed.
  function automatic sgn_t area_a(input logic signed [W-1:0] ax,
                                  input logic signed [W-1:0] ay,
                                  input logic signed [W-1:0] bx,
                                  input logic signed [W-1:0] by,
                                  input logic signed [W-1:0] cx,
                                  input logic signed [W-1:0] cy);
    sgn_t m1, m2, res;
    m1 = mul_sgn(diff_sgn(bx, ax), diff_sgn(cy, ay));
    m2 = mul_sgn(diff_sgn(by, ay), diff_sgn(cx, ax));
    res.pos = m1.pos | m2.neg;
    res.neg = m1.neg | m2.pos;
    return res;
  endfunction

  // General area sign: compare (bx-ax)*(cy-ay) with (by-ay)*(cx-ax)
  function automatic sgn_t area_g(input logic signed [W-1:0] ax,
                                  input logic signed [W-1:0] ay,
                                  input logic signed [W-1:0] bx,
                                  input logic signed [W-1:0] by,
                                  input logic signed [W-1:0] cx,
                                  input logic signed [W-1:0] cy);
    logic signed [2*W-1:0] p, q;
    sgn_t res;
    p = (2*W)'(bx - ax) * (2*W)'(cy - ay);
    q = (2*W)'(by - ay) * (2*W)'(cx - ax);
    res.pos = p > q;
    res.neg = p < q;
    return res;
  endfunction

  function automatic logic rmeet(input logic signed [W-1:0] a,
                                 input logic signed [W-1:0] b,
                                 input logic signed [W-1:0] c,
                                 input logic signed [W-1:0] d);
    logic signed [W-1:0] lo1, hi1, lo2, hi2, lo, hi;
    lo1 = (a > b) ? b : a;
    hi1 = (a > b) ? a : b;
    lo2 = (c > d) ? d : c;
    hi2 = (c > d) ? c : d;
    lo  = (lo1 > lo2) ? lo1 : lo2;
    hi  = (hi1 < hi2) ? hi1 : hi2;
    return lo <= hi;
  endfunction

  // Segment a is a box edge on an axis; segment b is the query segment
  function automatic logic lmeet(input logic signed [W-1:0] a1x,
                                 input logic signed [W-1:0] a1y,
                                 input logic signed [W-1:0] a2x,
                                 input logic signed [W-1:0] a2y,
                                 input logic signed [W-1:0] b1x,
                                 input logic signed [W-1:0] b1y,
                                 input logic signed [W-1:0] b2x,
                                 input logic signed [W-1:0] b2y);
    sgn_t s1, s2, s3, s4, m1, m2;
    s1 = area_a(a1x, a1y, a2x, a2y, b1x, b1y);
    s2 = area_a(a1x, a1y, a2x, a2y, b2x, b2y);
    s3 = area_g(b1x, b1y, b2x, b2y, a1x, a1y);
    s4 = area_g(b1x, b1y, b2x, b2y, a2x, a2y);
    m1 = mul_sgn(s1, s2);
    m2 = mul_sgn(s3, s4);
    return rmeet(a1x, a2x, b1x, b2x) & rmeet(a1y, a2y, b1y, b2y)
           & !m1.pos & !m2.pos;
  endfunction

  logic signed [W-1:0] l, t, r, b, px1, py1, px2, py2;
  assign l   = W'(lx_i);
  assign t   = W'(by_i);
  assign r   = W'(rx_i);
  assign b   = W'(ty_i);
  assign px1 = W'(x1_i);
  assign py1 = W'(y1_i);
  assign px2 = W'(x2_i);
  assign py2 = W'(y2_i);

  // Outcodes of both endpoints
  always_comb begin
    ca = '0;
    cb = '0;
    if (px1 < l) ca |= CodeLeft;
    if (px1 > r) ca |= CodeRight;
    if (py1 < t) ca |= CodeBottom;
    if (py1 > b) ca |= CodeTop;
    if (px2 < l) cb |= CodeLeft;
    if (px2 > r) cb |= CodeRight;
    if (py2 < t) cb |= CodeBottom;
    if (py2 > b) cb |= CodeTop;
  end

  // Edge tests; the box edge lies on an axis
  assign edge_l = lmeet(l, t, l, b, px1, py1, px2, py2);
  assign edge_r = lmeet(r, t, r, b, px1, py1, px2, py2);
  assign edge_b = lmeet(l, t, r, t, px1, py1, px2, py2);
  assign edge_t = lmeet(l, b, r, b, px1, py1, px2, py2);

  assign hit_o = ((ca & cb) == 4'd0) &&
                 ((ca == 4'd0) || (cb == 4'd0) || edge_l || edge_r || edge_b || edge_t);
endmodule
`default_nettype wire
